/* rtl/rldr_pkg.sv */
// ----------------------------------------------------------------------------
// rldr_pkg
// Shared constants and register codes for the radial lens distortion remap.
// ----------------------------------------------------------------------------
package rldr_pkg;

	// Default coordinate format: signed Q4.20 in 24 bits.
	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 20;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_COEF_CUBIC    = 3'd0,
		REG_COEF_SQUARE   = 3'd1,
		REG_COEF_LINEAR   = 3'd2,
		REG_COEF_CONSTANT = 3'd3,
		REG_CENTRE_X      = 3'd4,
		REG_CENTRE_Y      = 3'd5
	} reg_index_t;

endpackage

/* rtl/rldr_sqrt.sv */
// ----------------------------------------------------------------------------
// rldr_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rldr_sqrt #(
	parameter int W  = 24,
	parameter int PW = 49
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [2*W-1:0] radicand,
	input  logic [PW-1:0]  in_payload,
	output logic           out_valid,
	output logic [W-1:0]   root,
	output logic [PW-1:0]  out_payload
);

	logic [W:0]      rem_sn   [W];
	logic [W-1:0]    root_sn  [W];
	logic [2*W-1:0]  rad_sn   [W];
	logic [PW-1:0]   pay_sn   [W];
	logic [W-1:0]    valid_sn;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W:0]     rem_in;
		logic [W-1:0]   root_in;
		logic [2*W-1:0] rad_in;
		logic [PW-1:0]  pay_in;
		logic           valid_in;
		logic [W+2:0]   cat;
		logic [W+2:0]   trial;
		logic [W+2:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in   = '0;
			assign root_in  = '0;
			assign rad_in   = radicand;
			assign pay_in   = in_payload;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = rem_sn[k-1];
			assign root_in  = root_sn[k-1];
			assign rad_in   = rad_sn[k-1];
			assign pay_in   = pay_sn[k-1];
			assign valid_in = valid_sn[k-1];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign cat   = {rem_in, rad_in[2*W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff  = cat - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k] <= 1'b0;
			end else if (en) begin
				valid_sn[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sn[k] <= {rad_in[2*W-3:0], 2'b00};
				pay_sn[k] <= pay_in;
				if (cat >= trial) begin
					rem_sn[k]  <= diff[W:0];
					root_sn[k] <= {root_in[W-2:0], 1'b1};
				end else begin
					rem_sn[k]  <= cat[W:0];
					root_sn[k] <= {root_in[W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid   = valid_sn[W-1];
	assign root        = root_sn[W-1];
	assign out_payload = pay_sn[W-1];

endmodule

/* rtl/radial_lens_distortion_remap_core.sv */
// ----------------------------------------------------------------------------
// radial_lens_distortion_remap_core
// Maps a destination coordinate to its source under the radial lens model.
// ----------------------------------------------------------------------------
// One request enters per clock and one result leaves per clock when the
// output is taken. Three stages form the centre offset and the squared
// radius, the square root resolves one bit per stage over COORD_WIDTH
// stages, and eight stages evaluate the polynomial and the final products,
// alternating multiply stages with round-add-saturate stages. The
// whole pipeline holds while a result waits at the output and is not taken.
// Configuration must be written only while the pipeline is empty.
module radial_lens_distortion_remap_core
	import rldr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// dest_x, dest_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// source_x, source_y, clipped
	output logic [((2*COORD_WIDTH+8)/8)*8-1:0]   m_tdata,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_index,
	input  logic [COORD_WIDTH-1:0]               cfg_data
);

	localparam int W     = COORD_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int OUT_W = ((2*W+8)/8)*8;
	localparam int PW    = 2*W+1;
	localparam int PRODW = 2*W+2;

	localparam logic signed [PRODW-1:0] HI  = {{(W+2){1'b0}}, 1'b0, {(W-1){1'b1}}};
	localparam logic signed [PRODW-1:0] LO  = {{(W+2){1'b1}}, 1'b1, {(W-1){1'b0}}};
	localparam logic signed [PRODW-1:0] RND = {{(PRODW-1){1'b0}}, 1'b1} << (F-1);
	localparam logic [W-1:0] ONE = (F >= W-1) ? {1'b0, {(W-1){1'b1}}}
		: W'({{(W-1){1'b0}}, 1'b1} << F);

	// Round half up, drop the fraction bits, add, and saturate. Returns {clip, value}.
	function automatic logic [W:0] rnd_add(input logic signed [PRODW-1:0] prod,
		input logic signed [W-1:0] addv);
		logic signed [PRODW-1:0] s;
		s = (prod + RND) >>> F;
		s = s + addv;
		if (s > HI) begin
			return {1'b1, HI[W-1:0]};
		end else if (s < LO) begin
			return {1'b1, LO[W-1:0]};
		end
		return {1'b0, s[W-1:0]};
	endfunction

	// Subtract with saturation. Returns {clip, value}.
	function automatic logic [W:0] sat_sub(input logic [W-1:0] av, input logic [W-1:0] bv);
		logic [W:0] d;
		d = {av[W-1], av} - {bv[W-1], bv};
		if (d[W] != d[W-1]) begin
			return {1'b1, d[W], {(W-1){~d[W]}}};
		end
		return {1'b0, d[W-1:0]};
	endfunction

	// Configuration registers.
	logic signed [W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, cen_x_q, cen_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= ONE;
			cen_x_q  <= '0;
			cen_y_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_CUBIC:    coef_a_q <= cfg_data;
				REG_COEF_SQUARE:   coef_b_q <= cfg_data;
				REG_COEF_LINEAR:   coef_c_q <= cfg_data;
				REG_COEF_CONSTANT: coef_d_q <= cfg_data;
				REG_CENTRE_X:      cen_x_q  <= cfg_data;
				REG_CENTRE_Y:      cen_y_q  <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Global advance: everything moves unless a result waits untaken.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [W:0] subx, suby;
	assign subx = sat_sub(s_tdata[W-1:0], cen_x_q);
	assign suby = sat_sub(s_tdata[2*W-1:W], cen_y_q);

	logic                v_s1, v_s2, v_s3;
	logic signed [W-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic                clip_s1, clip_s2, clip_s3;
	logic [2*W-1:0]      sqx_s2, sqy_s2, sum_s3;

	logic                v_r;
	logic [W-1:0]        r_r;
	logic [PW-1:0]       pay_r;

	logic                v_p1, v_p2, v_p3, v_p4, v_p5, v_p6, v_p7;
	logic [W-1:0]        r_p1, r_p2, r_p3, r_p4;
	logic signed [W-1:0] dx_p1, dx_p2, dx_p3, dx_p4, dx_p5, dx_p6, dy_p1, dy_p2, dy_p3;
	logic signed [W-1:0] dy_p4, dy_p5, dy_p6;
	logic                clip_p1, clip_p2, clip_p3, clip_p4, clip_p5, clip_p6, clip_p7;
	logic signed [PRODW-1:0] m_p1, m_p3, m_p5, mx_p7, my_p7;
	logic signed [W-1:0] t_p2, t_p4, p_p6;
	logic [W:0]          t2n, t4n, p6n, sxn, syn;
	logic [W-1:0]        sx_p8, sy_p8;
	logic                clip_p8, v_p8;

	assign t2n = rnd_add(m_p1, coef_b_q);
	assign t4n = rnd_add(m_p3, coef_c_q);
	assign p6n = rnd_add(m_p5, coef_d_q);
	assign sxn = rnd_add(mx_p7, cen_x_q);
	assign syn = rnd_add(my_p7, cen_y_q);

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3} <= '0;
			{v_p1, v_p2, v_p3, v_p4, v_p5, v_p6, v_p7, v_p8} <= '0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_p1 <= v_r;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
			v_p5 <= v_p4;
			v_p6 <= v_p5;
			v_p7 <= v_p6;
			v_p8 <= v_p7;
		end
	end

	// Offset, squares and radicand.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= subx[W-1:0];
			dy_s1   <= suby[W-1:0];
			clip_s1 <= subx[W] | suby[W];
			sqx_s2  <= (2*W)'(dx_s1 * dx_s1);
			sqy_s2  <= (2*W)'(dy_s1 * dy_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			clip_s2 <= clip_s1;
			sum_s3  <= sqx_s2 + sqy_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			clip_s3 <= clip_s2;
		end
	end

	rldr_sqrt #(
		.W  (W),
		.PW (PW)
	) u_sqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s3),
		.radicand    (sum_s3),
		.in_payload  ({clip_s3, dy_s3, dx_s3}),
		.out_valid   (v_r),
		.root        (r_r),
		.out_payload (pay_r)
	);

	// Horner evaluation of the polynomial, then the two output products.
	always_ff @(posedge clk) begin
		if (en) begin
			m_p1    <= PRODW'(coef_a_q * $signed({1'b0, r_r}));
			r_p1    <= r_r;
			dx_p1   <= pay_r[W-1:0];
			dy_p1   <= pay_r[2*W-1:W];
			clip_p1 <= pay_r[2*W];

			t_p2    <= t2n[W-1:0];
			clip_p2 <= clip_p1 | t2n[W];
			r_p2    <= r_p1;
			dx_p2   <= dx_p1;
			dy_p2   <= dy_p1;

			m_p3    <= PRODW'(t_p2 * $signed({1'b0, r_p2}));
			clip_p3 <= clip_p2;
			r_p3    <= r_p2;
			dx_p3   <= dx_p2;
			dy_p3   <= dy_p2;

			t_p4    <= t4n[W-1:0];
			clip_p4 <= clip_p3 | t4n[W];
			r_p4    <= r_p3;
			dx_p4   <= dx_p3;
			dy_p4   <= dy_p3;

			m_p5    <= PRODW'(t_p4 * $signed({1'b0, r_p4}));
			clip_p5 <= clip_p4;
			dx_p5   <= dx_p4;
			dy_p5   <= dy_p4;

			p_p6    <= p6n[W-1:0];
			clip_p6 <= clip_p5 | p6n[W];
			dx_p6   <= dx_p5;
			dy_p6   <= dy_p5;

			mx_p7   <= PRODW'(dx_p6 * p_p6);
			my_p7   <= PRODW'(dy_p6 * p_p6);
			clip_p7 <= clip_p6;

			sx_p8   <= sxn[W-1:0];
			sy_p8   <= syn[W-1:0];
			clip_p8 <= clip_p7 | sxn[W] | syn[W];
		end
	end

	assign m_tvalid = v_p8;
	assign m_tdata  = OUT_W'({clip_p8, sy_p8, sx_p8});

`ifndef SYNTHESIS
	// A request in the first stage moves on whenever the pipeline advances.
	assert property (@(posedge clk) disable iff (!arst_n) en && v_s1 |=> v_s2)
		else $error("stage one request lost");
	// A held result stays valid while the pipeline is frozen.
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid && !m_tready |=> m_tvalid)
		else $error("held result dropped");
	// Nothing enters while the output stall freezes the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n) !en |=> $stable(v_p7) && $stable(v_s1))
		else $error("pipeline moved during stall");
`endif

endmodule
